### design/uart_16550_register_model_top_assert.svh
// Assertion macros for the UART register block.
`ifndef UART_16550_REGISTER_MODEL_TOP_ASSERT_SVH
`define UART_16550_REGISTER_MODEL_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define UART_RM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define UART_RM_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

### design/uart_rm_pkg.sv
`default_nettype none

package uart_rm_pkg;

    localparam int FIFO_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OFS_RBR = 3'd0,
        OFS_IER = 3'd1,
        OFS_IIR = 3'd2,
        OFS_LCR = 3'd3,
        OFS_MCR = 3'd4,
        OFS_LSR = 3'd5,
        OFS_MSR = 3'd6,
        OFS_SCR = 3'd7
    } reg_ofs_t;

    localparam logic [7:0] IIR_NONE    = 8'hc1;
    localparam logic [7:0] IIR_THR     = 8'hc2;
    localparam logic [7:0] IIR_RX      = 8'hc4;
    localparam logic [7:0] RDATA_EMPTY = 8'hff;
    localparam logic [3:0] ACC_BYTE    = 4'd1;

    localparam int LCR_DLAB_BIT  = 7;
    localparam int IER_RX_BIT    = 0;
    localparam int IER_THR_BIT   = 1;
    localparam int FCR_FLUSH_BIT = 1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic       irq;
        logic       rx_dropped;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       ok;
        logic       read_empty;
        logic [7:0] rdata;
    } result_t;

endpackage

`default_nettype wire

### design/uart_16550_register_model_top.sv
// 16550-style UART register block.
// Input channel s_*: one transaction is a bus read, a bus write or a byte
// received from the line (kind in s_tuser). Output channel m_*: exactly one
// result transaction per input transaction, in order.
// cfg_wr_en/cfg_wr_data set tx_ready; write it only while the block is idle.
// The first stage updates all registers and issues the receive-FIFO read;
// the second holds the result with the FIFO read data. Throughput: one
// transaction per cycle while m_tready stays high. The receive FIFO
// is a single memory with one write port (line bytes at the tail) and one
// registered read port (RBR reads at the head); each transaction uses at
// most one of them.
// Reset (aresetn low, synchronous): registers, FIFO pointers and interrupt
// state clear, IIR reads as no interrupt pending; FIFO contents are not
// cleared and need no clearing pass.
// Receiver stall: with m_tready low the output register holds and one more
// transaction is taken into the first stage; then s_tready drops until the
// output side moves again.
`default_nettype none

module uart_16550_register_model_top
    import uart_rm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,   // tx_ready
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] offset, [6:3] access_width, [14:7] wdata, [15] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] op
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] rdata, [8] read_empty, [9] ok, [10] tx_valid, [18:11] tx_byte,
    // [19] rx_dropped, [20] irq, [23:21] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    `include "uart_16550_register_model_top_assert.svh"

    op_t        in_op;
    reg_ofs_t   in_ofs;
    logic [3:0] in_width;
    logic [7:0] in_data;

    assign in_op    = op_t'(s_tuser);
    assign in_ofs   = reg_ofs_t'(s_tdata[2:0]);
    assign in_width = s_tdata[6:3];
    assign in_data  = s_tdata[14:7];

    // architectural state
    logic             tx_ready_reg;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [PTR_W-1:0] rx_tail_reg, rx_tail_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [7:0]       ier_reg, ier_next;
    logic [7:0]       dll_reg, dll_next;
    logic [7:0]       dlm_reg, dlm_next;
    logic [7:0]       iir_reg, iir_next;
    logic             data_ready_reg, data_ready_next;
    logic             thr_pending_reg, thr_pending_next;
    logic             irq_level_reg, irq_level_next;

    // pipeline
    logic             p1_valid_reg;
    logic             p1_use_mem_reg;
    result_t          p1_res_reg;
    result_t          step_res;
    logic             step_use_mem;
    logic             m_valid_reg;
    result_t          m_res_reg;
    result_t          p1_res_final;

    logic             out_adv;
    logic             accept;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_q_reg;
    logic [7:0]       fifo_mem [FIFO_DEPTH];

    assign out_adv  = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || out_adv;
    assign accept   = s_tvalid && s_tready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        logic dlab;
        logic reeval;
        logic byte_acc;
        dlab     = lcr_reg[LCR_DLAB_BIT];
        reeval   = 1'b0;
        byte_acc = (in_width == ACC_BYTE);

        rx_head_next     = rx_head_reg;
        rx_tail_next     = rx_tail_reg;
        rx_count_next    = rx_count_reg;
        lcr_next         = lcr_reg;
        ier_next         = ier_reg;
        dll_next         = dll_reg;
        dlm_next         = dlm_reg;
        iir_next         = iir_reg;
        data_ready_next  = data_ready_reg;
        thr_pending_next = thr_pending_reg;
        irq_level_next   = irq_level_reg;
        step_res         = '0;
        step_use_mem     = 1'b0;
        mem_we           = 1'b0;

        if (in_op == OP_READ && byte_acc) begin
            step_res.ok = 1'b1;
            unique case (in_ofs) inside
                OFS_RBR: begin
                    if (dlab) begin
                        step_res.rdata = dll_reg;
                    end else if (rx_count_reg == '0) begin
                        step_res.rdata      = RDATA_EMPTY;
                        step_res.read_empty = 1'b1;
                    end else begin
                        step_use_mem  = 1'b1;
                        rx_head_next  = ptr_inc(rx_head_reg);
                        rx_count_next = rx_count_reg - 1'b1;
                        if (rx_count_next == '0) begin
                            data_ready_next = 1'b0;
                        end
                        reeval = 1'b1;
                    end
                end
                OFS_IER: step_res.rdata = dlab ? dlm_reg : ier_reg;
                OFS_IIR: begin
                    step_res.rdata = iir_reg;
                    if (iir_reg[3:0] == IIR_THR[3:0]) begin
                        thr_pending_next = 1'b0;
                        reeval           = 1'b1;
                    end
                end
                OFS_LCR: step_res.rdata = lcr_reg;
                OFS_LSR: step_res.rdata = {1'b0, tx_ready_reg, tx_ready_reg, 4'b0,
                                           data_ready_reg};
                OFS_MCR, OFS_MSR, OFS_SCR: step_res.rdata = '0;
                default: step_res.rdata = '0;
            endcase
        end else if (in_op == OP_WRITE && byte_acc) begin
            step_res.ok = 1'b1;
            unique case (in_ofs) inside
                OFS_RBR: begin
                    if (dlab) begin
                        dll_next = in_data;
                    end else begin
                        step_res.tx_valid = 1'b1;
                        step_res.tx_byte  = in_data;
                        if (tx_ready_reg && ier_reg[IER_THR_BIT]) begin
                            thr_pending_next = 1'b1;
                        end
                        reeval = 1'b1;
                    end
                end
                OFS_IER: begin
                    if (dlab) begin
                        dlm_next = in_data;
                    end else begin
                        ier_next = in_data;
                        // THR-empty interrupt enabled on a rising IER bit
                        if (!ier_reg[IER_THR_BIT] && in_data[IER_THR_BIT] && tx_ready_reg) begin
                            thr_pending_next = 1'b1;
                        end
                        reeval = 1'b1;
                    end
                end
                OFS_IIR: begin
                    if (in_data[FCR_FLUSH_BIT]) begin
                        rx_head_next    = '0;
                        rx_tail_next    = '0;
                        rx_count_next   = '0;
                        data_ready_next = 1'b0;
                    end
                    reeval = 1'b1;
                end
                OFS_LCR: lcr_next = in_data;
                OFS_MCR, OFS_LSR, OFS_MSR, OFS_SCR: ;
                default: ;
            endcase
        end else if (in_op == OP_RX) begin
            if (rx_count_reg == CNT_W'(FIFO_DEPTH)) begin
                step_res.rx_dropped = 1'b1;
            end else begin
                mem_we          = 1'b1;
                rx_tail_next    = ptr_inc(rx_tail_reg);
                rx_count_next   = rx_count_reg + 1'b1;
                data_ready_next = 1'b1;
                reeval          = 1'b1;
            end
        end

        if (reeval) begin
            if (rx_count_next != '0 && ier_next[IER_RX_BIT]) begin
                iir_next       = IIR_RX;
                irq_level_next = 1'b1;
            end else if (thr_pending_next && ier_next[IER_THR_BIT]) begin
                iir_next       = IIR_THR;
                irq_level_next = 1'b1;
            end else begin
                iir_next       = IIR_NONE;
                irq_level_next = 1'b0;
            end
        end

        step_res.irq = irq_level_next;
    end

    assign mem_re = accept && step_use_mem;

    // receive FIFO storage, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            fifo_mem[rx_tail_reg] <= in_data;
        end
        if (mem_re) begin
            mem_q_reg <= fifo_mem[rx_head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_ready_reg    <= 1'b0;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            rx_count_reg    <= '0;
            lcr_reg         <= '0;
            ier_reg         <= '0;
            dll_reg         <= '0;
            dlm_reg         <= '0;
            iir_reg         <= IIR_NONE;
            data_ready_reg  <= 1'b0;
            thr_pending_reg <= 1'b0;
            irq_level_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tx_ready_reg <= cfg_wr_data;
            end
            if (accept) begin
                rx_head_reg     <= rx_head_next;
                rx_tail_reg     <= rx_tail_next;
                rx_count_reg    <= rx_count_next;
                lcr_reg         <= lcr_next;
                ier_reg         <= ier_next;
                dll_reg         <= dll_next;
                dlm_reg         <= dlm_next;
                iir_reg         <= iir_next;
                data_ready_reg  <= data_ready_next;
                thr_pending_reg <= thr_pending_next;
                irq_level_reg   <= irq_level_next;
            end
        end
    end

    // FIFO read data arrives with the first stage
    always_comb begin
        p1_res_final = p1_res_reg;
        if (p1_use_mem_reg) begin
            p1_res_final.rdata = mem_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (out_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (out_adv) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg     <= step_res;
            p1_use_mem_reg <= step_use_mem;
        end
        if (out_adv && p1_valid_reg) begin
            m_res_reg <= p1_res_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, m_res_reg.irq, m_res_reg.rx_dropped, m_res_reg.tx_byte,
                       m_res_reg.tx_valid, m_res_reg.ok, m_res_reg.read_empty,
                       m_res_reg.rdata};

    `UART_RM_ASSERT(a_count_bound, rx_count_reg <= CNT_W'(FIFO_DEPTH), "rx count above depth")
    `UART_RM_ASSERT(a_dr_tracks_count, data_ready_reg == (rx_count_reg != '0), "data ready mismatch")
    `UART_RM_ASSERT(a_irq_tracks_iir, irq_level_reg == (iir_reg != IIR_NONE), "irq and IIR disagree")
    `UART_RM_ASSERT_NEXT(a_p1_hold, p1_valid_reg && !out_adv, p1_valid_reg, "stage one lost")
    `UART_RM_ASSERT_NEXT(a_mem_read_once, mem_re, p1_valid_reg && p1_use_mem_reg, "FIFO read not staged")

endmodule

`default_nettype wire
